// ===== src/hcsk_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV color key package
// Shared widths, constants, register indexes and types of the color key core.
// ----------------------------------------------------------------------------
package hcsk_pkg;

	localparam int unsigned CHAN_W     = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_REF_RED        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_GREEN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_BLUE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_HUE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_SATURATION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_VALUE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE        = 3'd6;

	// Operating modes.
	localparam logic MODE_THRESHOLD  = 1'b0;
	localparam logic MODE_DESATURATE = 1'b1;

	// Hue sectors, named after the largest channel.
	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	localparam logic [CHAN_W-1:0] HUE_BASE_RED   = 8'd0;
	localparam logic [CHAN_W-1:0] HUE_BASE_GREEN = 8'd85;
	localparam logic [CHAN_W-1:0] HUE_BASE_BLUE  = 8'd171;
	localparam logic [CHAN_W-1:0] PIX_WHITE      = 8'd255;
	localparam logic [CHAN_W-1:0] PIX_BLACK      = 8'd0;

	localparam int unsigned HUE_SCALE = 43;
	localparam int unsigned SAT_SCALE = 255;

	// Divider: 16-bit dividend, 8-bit divisor and quotient, two bits a stage.
	localparam int unsigned DIV_NUM_W          = 2 * CHAN_W;
	localparam int unsigned DIV_BITS_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES         = CHAN_W / DIV_BITS_PER_STAGE;

	// Min/max stage, numerator stage, divider stages, hue assembly stage.
	localparam int unsigned HSV_STAGES = DIV_STAGES + 3;
	// Plus the compare and output stage.
	localparam int unsigned PIPE_STAGES = HSV_STAGES + 1;

	typedef struct packed {
		logic [CHAN_W-1:0] h;
		logic [CHAN_W-1:0] s;
		logic [CHAN_W-1:0] v;
	} hsv_t;

endpackage

// ===== src/hcsk_if.sv =====
// ----------------------------------------------------------------------------
// HSV color key channels
// Valid/ready channels for pixels, results and configuration writes.
// ----------------------------------------------------------------------------
interface hcsk_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, output in_red, output in_green, output in_blue,
		input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue,
		output ready);
endinterface

interface hcsk_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       is_match;
	logic [7:0] pixel_hue;
	logic [7:0] pixel_saturation;
	logic [7:0] pixel_value;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output is_match, output pixel_hue, output pixel_saturation,
		output pixel_value, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input is_match, input pixel_hue, input pixel_saturation,
		input pixel_value, output ready);
endinterface

interface hcsk_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/hcsk_div.sv =====
// ----------------------------------------------------------------------------
// HSV color key divider
// Pipelined restoring divider, 16-bit dividend by 8-bit divisor, for
// dividends whose quotient is known to fit in 8 bits.
// ----------------------------------------------------------------------------
module hcsk_div import hcsk_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [DIV_NUM_W-1:0]  num,
	input  logic [CHAN_W-1:0]     den,
	output logic [CHAN_W-1:0]     quo
);

	logic [CHAN_W-1:0] rem_s [DIV_STAGES];
	logic [CHAN_W-1:0] low_s [DIV_STAGES];
	logic [CHAN_W-1:0] den_s [DIV_STAGES];
	logic [CHAN_W-1:0] quo_s [DIV_STAGES];

	logic [CHAN_W-1:0] rem_d [DIV_STAGES];
	logic [CHAN_W-1:0] low_d [DIV_STAGES];
	logic [CHAN_W-1:0] den_d [DIV_STAGES];
	logic [CHAN_W-1:0] quo_d [DIV_STAGES];

	always_comb begin
		logic [CHAN_W:0]   t;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] l;
		logic [CHAN_W-1:0] dd;
		logic [CHAN_W-1:0] q;
		for (int k = 0; k < DIV_STAGES; k++) begin
			// The upper dividend half is below the divisor, so it seeds the remainder.
			if (k == 0) begin
				r  = num[DIV_NUM_W-1:CHAN_W];
				l  = num[CHAN_W-1:0];
				dd = den;
				q  = '0;
			end else begin
				r  = rem_s[k-1];
				l  = low_s[k-1];
				dd = den_s[k-1];
				q  = quo_s[k-1];
			end
			for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
				t = {r, l[CHAN_W-1]};
				l = {l[CHAN_W-2:0], 1'b0};
				if (t >= {1'b0, dd}) begin
					t = t - {1'b0, dd};
					q = {q[CHAN_W-2:0], 1'b1};
				end else begin
					q = {q[CHAN_W-2:0], 1'b0};
				end
				r = t[CHAN_W-1:0];
			end
			rem_d[k] = r;
			low_d[k] = l;
			den_d[k] = dd;
			quo_d[k] = q;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_d[k];
				low_s[k] <= low_d[k];
				den_s[k] <= den_d[k];
				quo_s[k] <= quo_d[k];
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// ===== src/hcsk_hsv.sv =====
// ----------------------------------------------------------------------------
// HSV color key converter
// Pipelined RGB888 to 8-bit HSV conversion: min/max, numerators, two
// dividers side by side, then hue assembly.
// ----------------------------------------------------------------------------
module hcsk_hsv import hcsk_pkg::*; (
	input  logic                  clk,
	input  logic [HSV_STAGES-1:0] en,
	input  logic [CHAN_W-1:0]     red,
	input  logic [CHAN_W-1:0]     green,
	input  logic [CHAN_W-1:0]     blue,
	output hsv_t                  hsv
);

	localparam int unsigned HNUM_W = 14;

	typedef struct packed {
		logic [CHAN_W-1:0] v;
		logic [1:0]        sector;
		logic              neg;
		logic              black;
		logic              gray;
	} side_t;

	function automatic logic [CHAN_W:0] sdiff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] m;
		m = (a >= b) ? (a - b) : (b - a);
		return {(a < b), m};
	endfunction

	// Stage 1: largest and smallest channel, sector and signed hue numerator.
	logic [CHAN_W-1:0] mx_s1, mn_s1, nabs_s1;
	logic [1:0]        sector_s1;
	logic              neg_s1;

	logic [CHAN_W-1:0] mx_d, mn_d;
	logic [1:0]        sector_d;
	logic [CHAN_W:0]   num_d;

	always_comb begin
		logic r_max, g_max;
		r_max = (red >= green) && (red >= blue);
		g_max = !r_max && (green >= blue);
		if (r_max) begin
			mx_d     = red;
			sector_d = SEC_RED;
			num_d    = sdiff(green, blue);
		end else if (g_max) begin
			mx_d     = green;
			sector_d = SEC_GREEN;
			num_d    = sdiff(blue, red);
		end else begin
			mx_d     = blue;
			sector_d = SEC_BLUE;
			num_d    = sdiff(red, green);
		end
		mn_d = red;
		if (green < mn_d) mn_d = green;
		if (blue < mn_d) mn_d = blue;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			mx_s1     <= mx_d;
			mn_s1     <= mn_d;
			sector_s1 <= sector_d;
			neg_s1    <= num_d[CHAN_W];
			nabs_s1   <= num_d[CHAN_W-1:0];
		end
	end

	// Stage 2: spread, and the dividends of saturation and hue.
	logic [CHAN_W-1:0]    spread_d;
	logic [DIV_NUM_W-1:0] snum_s2, hnum_s2;
	logic [CHAN_W-1:0]    sden_s2, hden_s2;
	side_t                side_s2;

	assign spread_d = mx_s1 - mn_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			snum_s2        <= DIV_NUM_W'(spread_d) * DIV_NUM_W'(SAT_SCALE);
			hnum_s2        <= DIV_NUM_W'(HNUM_W'(nabs_s1) * HNUM_W'(HUE_SCALE));
			sden_s2        <= mx_s1;
			hden_s2        <= spread_d;
			side_s2.v      <= mx_s1;
			side_s2.sector <= sector_s1;
			side_s2.neg    <= neg_s1;
			side_s2.black  <= (mx_s1 == '0);
			side_s2.gray   <= (spread_d == '0);
		end
	end

	// Dividers; the side information walks along with them.
	logic [CHAN_W-1:0] sat_q, hoff_q;
	side_t             side_s [DIV_STAGES];

	hcsk_div u_sat_div (
		.clk (clk),
		.en  (en[DIV_STAGES+1:2]),
		.num (snum_s2),
		.den (sden_s2),
		.quo (sat_q)
	);

	hcsk_div u_hue_div (
		.clk (clk),
		.en  (en[DIV_STAGES+1:2]),
		.num (hnum_s2),
		.den (hden_s2),
		.quo (hoff_q)
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[k+2]) begin
				side_s[k] <= (k == 0) ? side_s2 : side_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Last stage: hue from sector base and offset, with the zero cases.
	side_t             side_l;
	logic [CHAN_W-1:0] base_d, off_d;
	hsv_t              hsv_s7;

	assign side_l = side_s[DIV_STAGES-1];

	always_comb begin
		case (side_l.sector)
			SEC_RED:   base_d = HUE_BASE_RED;
			SEC_GREEN: base_d = HUE_BASE_GREEN;
			SEC_BLUE:  base_d = HUE_BASE_BLUE;
			default:   base_d = HUE_BASE_RED;
		endcase
		// Truncation toward zero: negate the magnitude quotient.
		off_d = side_l.neg ? (CHAN_W'(0) - hoff_q) : hoff_q;
	end

	always_ff @(posedge clk) begin
		if (en[HSV_STAGES-1]) begin
			hsv_s7.v <= side_l.v;
			hsv_s7.s <= side_l.black ? '0 : sat_q;
			hsv_s7.h <= (side_l.black || side_l.gray) ? '0 : (base_d + off_d);
		end
	end

	assign hsv = hsv_s7;

endmodule

// ===== src/hsv_color_key_threshold_core.sv =====
// ----------------------------------------------------------------------------
// HSV color key threshold core
// Converts RGB888 pixels to 8-bit HSV and keys them against a reference color.
// ----------------------------------------------------------------------------
// The core takes one pixel per clock while the result side is ready and
// returns one result per pixel, in order. It is an eight-stage pipeline,
// whose four middle stages are the saturation and hue dividers, two
// quotient bits per stage. Stages with no pixel in them fill while the
// result side holds off, so input requests keep being taken until every
// stage holds a pixel. The reference color goes through a second converter
// that runs every cycle, so a configuration write is seen by every pixel
// taken after it. Write the registers only while no pixel is inside the
// core.
// ----------------------------------------------------------------------------
module hsv_color_key_threshold_core import hcsk_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	hcsk_pixel_if.sink    pixel,
	hcsk_result_if.source result,
	hcsk_cfg_if.sink      cfg
);

	// Configuration registers.
	logic [CHAN_W-1:0] ref_red_q, ref_green_q, ref_blue_q;
	logic [CHAN_W-1:0] tol_hue_q, tol_sat_q, tol_val_q;
	logic              op_mode_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_red_q   <= '0;
			ref_green_q <= '0;
			ref_blue_q  <= '0;
			tol_hue_q   <= '0;
			tol_sat_q   <= '0;
			tol_val_q   <= '0;
			op_mode_q   <= MODE_THRESHOLD;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_REF_RED:        ref_red_q   <= cfg.data;
				REG_REF_GREEN:      ref_green_q <= cfg.data;
				REG_REF_BLUE:       ref_blue_q  <= cfg.data;
				REG_TOL_HUE:        tol_hue_q   <= cfg.data;
				REG_TOL_SATURATION: tol_sat_q   <= cfg.data;
				REG_TOL_VALUE:      tol_val_q   <= cfg.data;
				REG_OP_MODE:        op_mode_q   <= cfg.data[0];
				default:            ;
			endcase
		end
	end

	// Stage valid bits; a stage loads when it is empty or its successor loads.
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] en;

	always_comb begin
		en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || result.ready;
		for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < PIPE_STAGES; i++) begin
				if (en[i]) begin
					vld_q[i] <= (i == 0) ? pixel.valid : vld_q[(i == 0) ? 0 : i-1];
				end
			end
		end
	end

	assign pixel.ready = en[0];

	// Pixel and reference converters.
	hsv_t pix_hsv, ref_hsv;

	hcsk_hsv u_pix_hsv (
		.clk   (clk),
		.en    (en[HSV_STAGES-1:0]),
		.red   (pixel.in_red),
		.green (pixel.in_green),
		.blue  (pixel.in_blue),
		.hsv   (pix_hsv)
	);

	hcsk_hsv u_ref_hsv (
		.clk   (clk),
		.en    ({HSV_STAGES{1'b1}}),
		.red   (ref_red_q),
		.green (ref_green_q),
		.blue  (ref_blue_q),
		.hsv   (ref_hsv)
	);

	// Compare and output stage.
	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	logic              match_d;
	logic [CHAN_W-1:0] pix_d;
	logic [CHAN_W-1:0] pix_s8;
	logic              match_s8;
	hsv_t              hsv_s8;

	always_comb begin
		match_d = (absdiff(pix_hsv.h, ref_hsv.h) <= tol_hue_q) &&
			(absdiff(pix_hsv.s, ref_hsv.s) <= tol_sat_q) &&
			(absdiff(pix_hsv.v, ref_hsv.v) <= tol_val_q);
		if (op_mode_q == MODE_DESATURATE) begin
			pix_d = pix_hsv.v;
		end else begin
			pix_d = match_d ? PIX_WHITE : PIX_BLACK;
		end
	end

	always_ff @(posedge clk) begin
		if (en[PIPE_STAGES-1]) begin
			pix_s8   <= pix_d;
			match_s8 <= match_d;
			hsv_s8   <= pix_hsv;
		end
	end

	assign result.valid            = vld_q[PIPE_STAGES-1];
	assign result.out_red          = pix_s8;
	assign result.out_green        = pix_s8;
	assign result.out_blue         = pix_s8;
	assign result.is_match         = match_s8;
	assign result.pixel_hue        = hsv_s8.h;
	assign result.pixel_saturation = hsv_s8.s;
	assign result.pixel_value      = hsv_s8.v;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV color key threshold core testbench
// Sends RGB pixels through the core under several reference colors, tolerances
// and both output modes, and checks every result pixel, match flag and HSV
// field against a predictor that holds its own copy of the key registers.
// ----------------------------------------------------------------------------
module tb import hcsk_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              hit;
		hsv_t              hsv;
	} key_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hcsk_pixel_if  pixel_ch ();
	hcsk_result_if result_ch ();
	hcsk_cfg_if    cfg_ch ();

	hsv_color_key_threshold_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Local copy of the key registers.
	logic [CHAN_W-1:0] key_red, key_green, key_blue;
	logic [CHAN_W-1:0] tol_h, tol_s, tol_v;
	logic              key_mode;

	key_result_t keyed_pixel_q [$];
	int unsigned key_fail_cnt = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic hsv_t rgb_to_hsv8(input logic [CHAN_W-1:0] r, g, b);
		int   mx, mn, num, base, span;
		hsv_t o;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		o = '0;
		o.v = 8'(mx);
		// A gray or black pixel has neither saturation nor hue.
		if (mx == 0 || mx == mn)
			return o;
		span = mx - mn;
		o.s = 8'((int'(SAT_SCALE) * span) / mx);
		if (mx == int'(r)) begin
			base = int'(HUE_BASE_RED);
			num = int'(g) - int'(b);
		end else if (mx == int'(g)) begin
			base = int'(HUE_BASE_GREEN);
			num = int'(b) - int'(r);
		end else begin
			base = int'(HUE_BASE_BLUE);
			num = int'(r) - int'(g);
		end
		// Division truncates toward zero and the sum wraps to eight bits.
		o.h = 8'(base + (int'(HUE_SCALE) * num) / span);
		return o;
	endfunction

	function automatic logic [CHAN_W-1:0] chan_dist(input logic [CHAN_W-1:0] a, c);
		return (a > c) ? a - c : c - a;
	endfunction

	function automatic key_result_t key_pixel(input logic [CHAN_W-1:0] r, g, b);
		key_result_t       res;
		hsv_t              key_hsv;
		logic [CHAN_W-1:0] pix;
		res.hsv = rgb_to_hsv8(r, g, b);
		key_hsv = rgb_to_hsv8(key_red, key_green, key_blue);
		res.hit = (chan_dist(res.hsv.h, key_hsv.h) <= tol_h) &&
			(chan_dist(res.hsv.s, key_hsv.s) <= tol_s) &&
			(chan_dist(res.hsv.v, key_hsv.v) <= tol_v);
		if (key_mode == MODE_DESATURATE)
			pix = res.hsv.v;
		else
			pix = res.hit ? PIX_WHITE : PIX_BLACK;
		res.red = pix;
		res.green = pix;
		res.blue = pix;
		return res;
	endfunction

	function automatic logic [CHAN_W-1:0] clamp_chan(input int x);
		if (x < 0) return 8'd0;
		if (x > 255) return 8'd255;
		return 8'(x);
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		key_fail_cnt++;
		if (key_fail_cnt <= MAX_REPORTS)
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	task automatic compare_field(input string what, input logic [CHAN_W-1:0] want,
		input logic [CHAN_W-1:0] got);
		if (got !== want) begin
			key_fail_cnt++;
			if (key_fail_cnt <= MAX_REPORTS)
				$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		key_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (keyed_pixel_q.size() == 0) begin
				note_mismatch("result with no pixel pending", 0, 1);
			end else begin
				want = keyed_pixel_q.pop_front();
				compare_field("out_red", want.red, result_ch.out_red);
				compare_field("out_green", want.green, result_ch.out_green);
				compare_field("out_blue", want.blue, result_ch.out_blue);
				compare_field("is_match", {7'd0, want.hit}, {7'd0, result_ch.is_match});
				compare_field("pixel_hue", want.hsv.h, result_ch.pixel_hue);
				compare_field("pixel_saturation", want.hsv.s, result_ch.pixel_saturation);
				compare_field("pixel_value", want.hsv.v, result_ch.pixel_value);
			end
		end
	end

	// Result side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			result_ch.ready <= 1'b0;
			rx_hold_cycles--;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
		while ($urandom_range(99) < tx_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.in_red <= r;
		pixel_ch.in_green <= g;
		pixel_ch.in_blue <= b;
		do @(posedge clk); while (!pixel_ch.ready);
		keyed_pixel_q.insert(keyed_pixel_q.size(), key_pixel(r, g, b));
	endtask

	task automatic drain_pixels();
		pixel_ch.valid <= 1'b0;
		do @(posedge clk); while (keyed_pixel_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_REF_RED:        key_red = data;
			REG_REF_GREEN:      key_green = data;
			REG_REF_BLUE:       key_blue = data;
			REG_TOL_HUE:        tol_h = data;
			REG_TOL_SATURATION: tol_s = data;
			REG_TOL_VALUE:      tol_v = data;
			REG_OP_MODE:        key_mode = data[0];
			default: ;
		endcase
	endtask

	task automatic cfg_idle();
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Registers are only written with no pixel inside the core.
	task automatic load_key(input logic [CHAN_W-1:0] r, g, b, th, ts, tv,
		input logic [CFG_DATA_W-1:0] mode_data);
		drain_pixels();
		write_reg(REG_REF_RED, r);
		write_reg(REG_REF_GREEN, g);
		write_reg(REG_REF_BLUE, b);
		write_reg(REG_TOL_HUE, th);
		write_reg(REG_TOL_SATURATION, ts);
		write_reg(REG_TOL_VALUE, tv);
		write_reg(REG_OP_MODE, mode_data);
		cfg_idle();
	endtask

	function automatic logic [CHAN_W-1:0] pick_ref_chan();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [CHAN_W-1:0] pick_tol();
		case ($urandom_range(3))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(24));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_key(input int unsigned chunk_no);
		logic [CHAN_W-1:0] th, ts, tv;
		if (chunk_no == 0) begin
			th = 8'd0;
			ts = 8'd0;
			tv = 8'd0;
		end else if (chunk_no == 1) begin
			th = 8'd255;
			ts = 8'd255;
			tv = 8'd255;
		end else begin
			th = pick_tol();
			ts = pick_tol();
			tv = pick_tol();
		end
		// The mode register only keeps bit 0, so the upper bits are random too.
		load_key(pick_ref_chan(), pick_ref_chan(), pick_ref_chan(), th, ts, tv,
			8'($urandom_range(255)));
	endtask

	task automatic send_random_pixel();
		logic [CHAN_W-1:0] r, g, b;
		case ($urandom_range(9))
			0, 1, 2, 3: begin
				// Close to the key color, so that matches and near misses are common.
				r = clamp_chan(int'(key_red) + int'($urandom_range(24)) - 12);
				g = clamp_chan(int'(key_green) + int'($urandom_range(24)) - 12);
				b = clamp_chan(int'(key_blue) + int'($urandom_range(24)) - 12);
			end
			4: begin
				r = $urandom_range(1) ? 8'd255 : 8'($urandom_range(1));
				g = $urandom_range(1) ? 8'd255 : 8'($urandom_range(1));
				b = $urandom_range(1) ? 8'($urandom_range(254, 255)) : 8'd0;
			end
			5: begin
				r = 8'($urandom_range(255));
				g = r;
				b = r;
			end
			default: begin
				r = 8'($urandom_range(255));
				g = 8'($urandom_range(255));
				b = 8'($urandom_range(255));
			end
		endcase
		send_pixel(r, g, b);
	endtask

	task automatic test_reset_state();
		// After reset the key is black with zero tolerances in threshold mode.
		key_red = '0;
		key_green = '0;
		key_blue = '0;
		tol_h = '0;
		tol_s = '0;
		tol_v = '0;
		key_mode = MODE_THRESHOLD;
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd255, 8'd255);
	endtask

	task automatic test_directed_pixels();
		logic [23:0] corner_pix [11];
		corner_pix = '{24'hFFFFFF, 24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFF0001, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080, 24'hC8283C};
		load_key(8'd200, 8'd40, 8'd40, 8'd10, 8'd30, 8'd30, {7'd0, MODE_THRESHOLD});
		foreach (corner_pix[i])
			send_pixel(corner_pix[i][23:16], corner_pix[i][15:8], corner_pix[i][7:0]);
		load_key(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, {7'd0, MODE_DESATURATE});
		foreach (corner_pix[i])
			send_pixel(corner_pix[i][23:16], corner_pix[i][15:8], corner_pix[i][7:0]);
	endtask

	task automatic test_register_corners();
		load_key(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, {7'd0, MODE_DESATURATE});
		// A write to the unused index changes nothing, and only bit 0 sets the mode.
		write_reg(REG_UNUSED, 8'hA5);
		write_reg(REG_OP_MODE, 8'hFE);
		cfg_idle();
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd254, 8'd0, 8'd0);
	endtask

	task automatic test_random_keys(input int unsigned n);
		int unsigned left, chunk_no, burst;
		left = n;
		chunk_no = 0;
		while (left > 0) begin
			burst = $urandom_range(25, 55);
			if (burst > left)
				burst = left;
			random_key(chunk_no);
			repeat (burst) send_random_pixel();
			left -= burst;
			chunk_no++;
		end
	endtask

	task automatic test_receiver_hold();
		int unsigned saved_tx_idle;
		saved_tx_idle = tx_idle_pct;
		random_key(2);
		// The core fills while the result side holds off, then must stall its input.
		tx_idle_pct = 0;
		rx_hold_cycles = 80;
		repeat (40) send_random_pixel();
		tx_idle_pct = saved_tx_idle;
		drain_pixels();
	endtask

	initial begin
		arst_n <= 1'b0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.in_red <= '0;
		pixel_ch.in_green <= '0;
		pixel_ch.in_blue <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 26;
		rx_idle_pct = 84;
		test_reset_state();
		test_directed_pixels();
		test_register_corners();
		test_random_keys(280);
		test_receiver_hold();

		tx_idle_pct = 84;
		rx_idle_pct = 26;
		test_random_keys(260);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_keys(270);

		drain_pixels();
		repeat (4 * PIPE_STAGES) @(posedge clk);
		if (key_fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
